// ===== rtl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo position ramp package
// Types, codes and fixed constants shared by the servo ramp units.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

	// Speed is used clamped to 1..SPEED_MAX.
	localparam int SPEED_MAX = 100;

	localparam int POS_W   = 8;
	localparam int PULSE_W = 16;
	localparam int SPEED_W = 7;
	localparam int TMR_W   = 10;
	localparam int CMD_W   = 3;
	localparam int CFG_W   = 16;
	localparam int ADDR_W  = 3;

	// Command codes of the input word.
	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ACT    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DEACT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DIRECT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_GRAD   = 3'd4;

	// Register indexes of the configuration port.
	localparam logic [ADDR_W-1:0] REG_CH0_POS_MIN = 3'd0;
	localparam logic [ADDR_W-1:0] REG_CH0_POS_MAX = 3'd1;
	localparam logic [ADDR_W-1:0] REG_CH1_POS_MIN = 3'd2;
	localparam logic [ADDR_W-1:0] REG_CH1_POS_MAX = 3'd3;
	localparam logic [ADDR_W-1:0] REG_PULSE_MIN   = 3'd4;
	localparam logic [ADDR_W-1:0] REG_PULSE_MAX   = 3'd5;
	localparam logic [ADDR_W-1:0] REG_CH0_SPEED   = 3'd6;
	localparam logic [ADDR_W-1:0] REG_CH1_SPEED   = 3'd7;

	// Shared divider: 24-bit dividend, 8-bit divisor, two quotient bits a cycle.
	localparam int DIV_W     = 24;
	localparam int DVS_W     = 8;
	localparam int DIV_RADIX = 2;
	localparam int DIV_ITER  = DIV_W / DIV_RADIX;

	localparam logic [DIV_W-1:0]   DLY_NUM    = 24'd1000;
	localparam logic [SPEED_W-1:0] SLOW_SPEED = 7'd10;
	localparam logic [TMR_W-1:0]   SLOW_TRIM  = 10'd17;
	localparam logic [SPEED_W-1:0] SPEED_CAP  =
		(SPEED_MAX > 127) ? 7'd127 : SPEED_W'(SPEED_MAX);

	typedef enum logic [2:0] {
		OP_NOP,
		OP_TICK,
		OP_ACT,
		OP_DEACT,
		OP_DIRECT,
		OP_GRAD
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             chan;
		logic [POS_W-1:0] position;
	} item_t;

	typedef struct packed {
		logic [1:0][POS_W-1:0]   pos_min;
		logic [1:0][POS_W-1:0]   pos_max;
		logic [PULSE_W-1:0]      pulse_min;
		logic [PULSE_W-1:0]      pulse_max;
		logic [1:0][SPEED_W-1:0] speed;
	} cfg_t;

	typedef struct packed {
		logic [PULSE_W-1:0] cmp_ch0;
		logic [PULSE_W-1:0] cmp_ch1;
		logic               on_ch0;
		logic               on_ch1;
		logic [POS_W-1:0]   pos_ch0;
		logic [POS_W-1:0]   pos_ch1;
		logic               busy_ch0;
		logic               busy_ch1;
	} res_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TICK_CH,
		ST_TICK_NEXT,
		ST_MAP_PREP,
		ST_MAP_DIV,
		ST_MAP_WAIT,
		ST_DLY_DIV,
		ST_DLY_WAIT,
		ST_EMIT
	} st_t;

endpackage

`default_nettype wire

// ===== rtl/spr_fifo.sv =====
// ----------------------------------------------------------------------------
// Small word queue
// Register-based first-in first-out queue used on both sides of the ramp unit.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_fifo #(
	parameter int DEPTH = 2,
	parameter int W     = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue holds more words than its depth");

endmodule

`default_nettype wire

// ===== rtl/spr_front.sv =====
// ----------------------------------------------------------------------------
// Servo ramp command front end
// Takes command words, sorts them into operations and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_front
	import spr_pkg::*;
#(
	parameter int NUM_CHANNELS = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [CMD_W-1:0] cmd,
	input  wire logic             chan,
	input  wire logic [POS_W-1:0] position,
	output logic                  item_valid,
	output item_t                 item,
	input  wire logic             item_pop
);

	item_t                   in_item;
	logic                    chan_ok;
	logic                    q_empty;
	logic [$bits(item_t)-1:0] q_rdata;

	assign chan_ok = ({31'b0, chan} < 32'(NUM_CHANNELS));

	// Commands to a channel that does not exist, and unused codes, do nothing.
	always_comb begin
		in_item.chan     = chan;
		in_item.position = position;
		unique case (cmd)
			CMD_TICK:   in_item.op = OP_TICK;
			CMD_ACT:    in_item.op = chan_ok ? OP_ACT : OP_NOP;
			CMD_DEACT:  in_item.op = chan_ok ? OP_DEACT : OP_NOP;
			CMD_DIRECT: in_item.op = chan_ok ? OP_DIRECT : OP_NOP;
			CMD_GRAD:   in_item.op = chan_ok ? OP_GRAD : OP_NOP;
			default:    in_item.op = OP_NOP;
		endcase
	end

	spr_fifo #(
		.DEPTH(2),
		.W($bits(item_t))
	) u_cmd_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(in_item),
		.full(full),
		.pop(item_pop),
		.rdata(q_rdata),
		.empty(q_empty)
	);

	assign item_valid = !q_empty;
	assign item       = item_t'(q_rdata);

endmodule

`default_nettype wire

// ===== rtl/spr_div.sv =====
// ----------------------------------------------------------------------------
// Servo ramp divider
// Iterative unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_div
	import spr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int CNT_W = $clog2(DIV_ITER + 1);

	logic [DIV_W-1:0] acc_q, acc_d;
	logic [DVS_W-1:0] rem_q, rem_d, dvs_q;
	logic [DVS_W:0]   trial;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;

	// The accumulator shifts dividend bits out at the top and quotient bits in
	// at the bottom.
	always_comb begin
		rem_d = rem_q;
		acc_d = acc_q;
		trial = '0;
		for (int k = 0; k < DIV_RADIX; k++) begin
			trial = {rem_d, acc_d[DIV_W-1]};
			acc_d = {acc_d[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				trial    = trial - {1'b0, dvs_q};
				acc_d[0] = 1'b1;
			end
			rem_d = trial[DVS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			acc_q <= acc_d;
			rem_q <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_ITER);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = acc_q;
	assign rsp.rem  = rem_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("division started while another is running");

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("division finished without having run");

endmodule

`default_nettype wire

// ===== rtl/spr_exec.sv =====
// ----------------------------------------------------------------------------
// Servo ramp execution unit
// Holds the channel state, carries out queued operations and builds results.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_exec
	import spr_pkg::*;
#(
	parameter int NUM_CHANNELS = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  item_valid,
	input  wire item_t item,
	output logic       item_pop,
	input  wire logic  res_full,
	output logic       res_push,
	output res_t       res
);

	st_t st_q, st_d;
	op_t op_q;
	logic             ch_q;
	logic [POS_W-1:0] pos_q;

	logic [POS_W-1:0]   cur_pos_q [NUM_CHANNELS];
	logic [POS_W-1:0]   tgt_pos_q [NUM_CHANNELS];
	logic [TMR_W-1:0]   tmr_q     [NUM_CHANNELS];
	logic [PULSE_W-1:0] cmpv_q    [NUM_CHANNELS];
	logic               on_q      [NUM_CHANNELS];

	logic [DIV_W-1:0] prod_q;
	logic [DVS_W-1:0] span_q;
	logic             neg_q, flat_q;

	logic [POS_W-1:0]   lo, hi, raw, clamped, cur_c, tgt_c, xl;
	logic [TMR_W-1:0]   tmr_c, tmr_dec, dly_val;
	logic               moving, step_now, last_ch, slow;
	logic [SPEED_W-1:0] s_raw, s_eff;
	logic [PULSE_W:0]   diff;
	logic [PULSE_W-1:0] mag16, qadj, map_val;
	st_t                map_next;

	div_req_t div_req;
	div_rsp_t div_rsp;

	spr_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	// Operands for the channel in hand.
	assign lo    = cfg.pos_min[ch_q];
	assign hi    = cfg.pos_max[ch_q];
	assign cur_c = cur_pos_q[ch_q];
	assign tgt_c = tgt_pos_q[ch_q];
	assign tmr_c = tmr_q[ch_q];

	// A tick maps the stepped position, which may lie outside changed limits.
	assign raw     = (op_q == OP_TICK) ? cur_c : pos_q;
	assign clamped = (raw < lo) ? lo : ((raw > hi) ? hi : raw);
	assign xl      = clamped - lo;

	assign moving   = (cur_c != tgt_c);
	assign tmr_dec  = (tmr_c == '0) ? '0 : tmr_c - TMR_W'(1);
	assign step_now = (tmr_dec == '0);
	assign last_ch  = (ch_q == 1'(NUM_CHANNELS - 1));

	assign s_raw = cfg.speed[ch_q];
	assign s_eff = (s_raw == '0) ? SPEED_W'(1) : ((s_raw > SPEED_CAP) ? SPEED_CAP : s_raw);
	assign slow  = (s_eff <= SLOW_SPEED);

	assign diff  = {1'b0, cfg.pulse_max} - {1'b0, cfg.pulse_min};
	assign mag16 = diff[PULSE_W] ? PULSE_W'(~diff[PULSE_W-1:0] + PULSE_W'(1))
		: diff[PULSE_W-1:0];

	// A descending map rounds the quotient away from zero, i.e. towards minus
	// infinity once negated.
	assign qadj    = div_rsp.quot[PULSE_W-1:0]
		+ PULSE_W'(neg_q && (div_rsp.rem != '0));
	assign map_val = flat_q ? cfg.pulse_min
		: cfg.pulse_min + (neg_q ? PULSE_W'(~qadj + PULSE_W'(1)) : qadj);
	assign dly_val = div_rsp.quot[TMR_W-1:0] - (slow ? SLOW_TRIM : '0);

	assign map_next = (op_q == OP_TICK) ? ST_DLY_DIV : ST_EMIT;

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (item_valid && !res_full) st_d = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (op_q) inside
					OP_TICK:            st_d = ST_TICK_CH;
					OP_ACT, OP_DIRECT:  st_d = ST_MAP_PREP;
					OP_GRAD:            st_d = ST_DLY_DIV;
					default:            st_d = ST_EMIT;
				endcase
			end
			ST_TICK_CH: begin
				st_d = (moving && step_now) ? ST_MAP_PREP : ST_TICK_NEXT;
			end
			ST_TICK_NEXT: begin
				st_d = last_ch ? ST_EMIT : ST_TICK_CH;
			end
			ST_MAP_PREP: begin
				st_d = ST_MAP_DIV;
			end
			ST_MAP_DIV: begin
				st_d = flat_q ? map_next : ST_MAP_WAIT;
			end
			ST_MAP_WAIT: begin
				if (div_rsp.done) st_d = map_next;
			end
			ST_DLY_DIV: begin
				st_d = ST_DLY_WAIT;
			end
			ST_DLY_WAIT: begin
				if (div_rsp.done) st_d = (op_q == OP_TICK) ? ST_TICK_NEXT : ST_EMIT;
			end
			ST_EMIT: begin
				st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		item_pop         = (st_q == ST_IDLE) && item_valid && !res_full;
		res_push         = (st_q == ST_EMIT);
		div_req.start    = ((st_q == ST_MAP_DIV) && !flat_q) || (st_q == ST_DLY_DIV);
		div_req.dividend = (st_q == ST_DLY_DIV) ? DLY_NUM : prod_q;
		div_req.divisor  = (st_q == ST_DLY_DIV) ? DVS_W'(s_eff) : span_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			op_q   <= OP_NOP;
			ch_q   <= 1'b0;
			pos_q  <= '0;
			flat_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (item_pop) begin
				op_q  <= item.op;
				ch_q  <= (item.op == OP_TICK) ? 1'b0 : item.chan;
				pos_q <= item.position;
			end
			if (st_q == ST_TICK_NEXT && !last_ch) begin
				ch_q <= ch_q + 1'b1;
			end
			if (st_q == ST_MAP_PREP) begin
				flat_q <= (hi <= lo);
			end
		end
	end

	// Product of the map, registered ahead of the divider.
	always_ff @(posedge clk) begin
		if (st_q == ST_MAP_PREP) begin
			prod_q <= {8'b0, mag16} * {16'b0, xl};
			span_q <= hi - lo;
			neg_q  <= diff[PULSE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				cur_pos_q[i] <= '0;
				tgt_pos_q[i] <= '0;
				tmr_q[i]     <= '0;
				cmpv_q[i]    <= '0;
				on_q[i]      <= 1'b0;
			end
		end else begin
			case (st_q)
				ST_DECODE: begin
					case (op_q)
						OP_ACT: begin
							cur_pos_q[ch_q] <= clamped;
							tgt_pos_q[ch_q] <= clamped;
							on_q[ch_q]      <= 1'b1;
						end
						OP_DIRECT: begin
							cur_pos_q[ch_q] <= clamped;
							tgt_pos_q[ch_q] <= clamped;
						end
						OP_DEACT: begin
							on_q[ch_q]      <= 1'b0;
							cmpv_q[ch_q]    <= '0;
							tgt_pos_q[ch_q] <= cur_c;
						end
						OP_GRAD: begin
							tgt_pos_q[ch_q] <= clamped;
						end
						default: ;
					endcase
				end
				ST_TICK_CH: begin
					if (moving) begin
						if (step_now) begin
							cur_pos_q[ch_q] <= (cur_c < tgt_c) ? cur_c + POS_W'(1)
								: cur_c - POS_W'(1);
						end else begin
							tmr_q[ch_q] <= tmr_dec;
						end
					end
				end
				ST_MAP_DIV: begin
					if (flat_q) cmpv_q[ch_q] <= map_val;
				end
				ST_MAP_WAIT: begin
					if (div_rsp.done) cmpv_q[ch_q] <= map_val;
				end
				ST_DLY_WAIT: begin
					if (div_rsp.done) tmr_q[ch_q] <= dly_val;
				end
				default: ;
			endcase
		end
	end

	// Result word from the current state; absent channels read as zero.
	logic [1:0][PULSE_W-1:0] cmp_o;
	logic [1:0][POS_W-1:0]   pos_o;
	logic [1:0]              on_o, busy_o;

	for (genvar k = 0; k < 2; k++) begin : g_out
		if (k < NUM_CHANNELS) begin : g_chan
			assign on_o[k]   = on_q[k];
			assign cmp_o[k]  = on_q[k] ? cmpv_q[k] : '0;
			assign pos_o[k]  = cur_pos_q[k];
			assign busy_o[k] = (cur_pos_q[k] != tgt_pos_q[k]);
		end else begin : g_none
			assign on_o[k]   = 1'b0;
			assign cmp_o[k]  = '0;
			assign pos_o[k]  = '0;
			assign busy_o[k] = 1'b0;
		end
	end

	assign res.cmp_ch0  = cmp_o[0];
	assign res.cmp_ch1  = cmp_o[1];
	assign res.on_ch0   = on_o[0];
	assign res.on_ch1   = on_o[1];
	assign res.pos_ch0  = pos_o[0];
	assign res.pos_ch1  = pos_o[1];
	assign res.busy_ch0 = busy_o[0];
	assign res.busy_ch1 = busy_o[1];

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result word pushed into a full queue");

	a_wait_has_div: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MAP_WAIT || st_q == ST_DLY_WAIT) |-> (div_rsp.busy || div_rsp.done))
		else $error("waiting on a divider that is not running");

endmodule

`default_nettype wire

// ===== rtl/servo_position_ramp_pwm_unit.sv =====
// ----------------------------------------------------------------------------
// Servo position ramp unit
// Two-channel servo position ramp with linear pulse compare mapping.
// ----------------------------------------------------------------------------
//  Port group   Handshake        Contents
//  command      push / full      cmd, chan, position
//  result       pop / empty      cmp_ch*, on_ch*, pos_ch*, busy_ch*
//  config       cfg_we           cfg_addr, cfg_data (no wait, no read-back)
//
// A no-op or deactivate needs no division; a direct or activating move divides
// once for the pulse map, a gradual move once for the step delay, and a tick
// up to twice for each stepping channel. All of these share one divider,
// which a tick of two stepping channels uses up to four times.
// Two-word queues on both sides let commands be taken while results wait.
// Reset clears all channel state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_position_ramp_pwm_unit
	import spr_pkg::*;
#(
	parameter int NUM_CHANNELS = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [CMD_W-1:0]  cmd,
	input  wire logic              chan,
	input  wire logic [POS_W-1:0]  position,
	output logic                   empty,
	input  wire logic              pop,
	output logic [PULSE_W-1:0]     cmp_ch0,
	output logic [PULSE_W-1:0]     cmp_ch1,
	output logic                   on_ch0,
	output logic                   on_ch1,
	output logic [POS_W-1:0]       pos_ch0,
	output logic [POS_W-1:0]       pos_ch1,
	output logic                   busy_ch0,
	output logic                   busy_ch1,
	input  wire logic              cfg_we,
	input  wire logic [ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	cfg_t  cfg_q;
	item_t item;
	logic  item_valid, item_pop;
	logic  res_push, res_full;
	res_t  res_in, res_out;
	logic [$bits(res_t)-1:0] res_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_min   <= {8'd0, 8'd0};
			cfg_q.pos_max   <= {8'd180, 8'd180};
			cfg_q.pulse_min <= 16'd1000;
			cfg_q.pulse_max <= 16'd5000;
			cfg_q.speed     <= {7'd60, 7'd60};
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_CH0_POS_MIN: cfg_q.pos_min[0] <= cfg_data[POS_W-1:0];
				REG_CH0_POS_MAX: cfg_q.pos_max[0] <= cfg_data[POS_W-1:0];
				REG_CH1_POS_MIN: cfg_q.pos_min[1] <= cfg_data[POS_W-1:0];
				REG_CH1_POS_MAX: cfg_q.pos_max[1] <= cfg_data[POS_W-1:0];
				REG_PULSE_MIN:   cfg_q.pulse_min  <= cfg_data[PULSE_W-1:0];
				REG_PULSE_MAX:   cfg_q.pulse_max  <= cfg_data[PULSE_W-1:0];
				REG_CH0_SPEED:   cfg_q.speed[0]   <= cfg_data[SPEED_W-1:0];
				REG_CH1_SPEED:   cfg_q.speed[1]   <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	spr_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.chan(chan),
		.position(position),
		.item_valid(item_valid),
		.item(item),
		.item_pop(item_pop)
	);

	spr_exec #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_exec (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item_valid(item_valid),
		.item(item),
		.item_pop(item_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res(res_in)
	);

	spr_fifo #(
		.DEPTH(2),
		.W($bits(res_t))
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res_in),
		.full(res_full),
		.pop(pop),
		.rdata(res_rdata),
		.empty(empty)
	);

	assign res_out  = res_t'(res_rdata);
	assign cmp_ch0  = res_out.cmp_ch0;
	assign cmp_ch1  = res_out.cmp_ch1;
	assign on_ch0   = res_out.on_ch0;
	assign on_ch1   = res_out.on_ch1;
	assign pos_ch0  = res_out.pos_ch0;
	assign pos_ch1  = res_out.pos_ch1;
	assign busy_ch0 = res_out.busy_ch0;
	assign busy_ch1 = res_out.busy_ch1;

endmodule

`default_nettype wire
